// ===== src/ara_pkg.sv =====
package ara_pkg;

  // Fixed field widths of the request and result beats.
  localparam int ADDR_W = 47;
  localparam int LEN_W  = 47;
  localparam int PROT_W = 3;
  localparam int OPC_W  = 2;
  localparam int STAT_W = 2;
  localparam int BASE_W = 35;
  localparam int ATTR_W = 4;

  localparam logic [35:0] REGION_BASE_ADDR = 36'h700000000;

  localparam logic [OPC_W-1:0] OP_RESERVE = 2'd0;
  localparam logic [OPC_W-1:0] OP_MAP     = 2'd1;
  localparam logic [OPC_W-1:0] OP_UNMAP   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVAL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd3;

  // Commands broadcast to every cell of the range chain.
  typedef logic [2:0] cmd_t;
  localparam cmd_t CMD_HOLD   = 3'd0;
  localparam cmd_t CMD_ROTATE = 3'd1;
  localparam cmd_t CMD_FLAGS  = 3'd2;
  localparam cmd_t CMD_TRIM   = 3'd3;
  localparam cmd_t CMD_REMOVE = 3'd4;
  localparam cmd_t CMD_SPLIT  = 3'd5;
  localparam cmd_t CMD_INSERT = 3'd6;

  // Per-cell status handed to the neighbors and to the sequencer.
  typedef struct packed {
    logic ge;   // entry sits at or after the insertion key (or is empty)
    logic cov;  // entry lies wholly inside the hole
    logic spl;  // entry straddles the hole on both sides
  } flags_t;

endpackage

// ===== src/ara_cell.sv =====
module ara_cell #(
  parameter int W = 37
) (
  input  logic                      clk,
  input  ara_pkg::cmd_t             cmd,
  input  logic                      valid,
  input  logic [W-1:0]              h0,
  input  logic [W-1:0]              h1,
  input  logic [W-1:0]              new_start,
  input  logic [W-1:0]              new_pages,
  input  logic [ara_pkg::ATTR_W-1:0] new_attr,
  input  logic [W-1:0]              lft_start,
  input  logic [W-1:0]              lft_pages,
  input  logic [ara_pkg::ATTR_W-1:0] lft_attr,
  input  ara_pkg::flags_t           lft_flags,
  input  logic [W-1:0]              rgt_start,
  input  logic [W-1:0]              rgt_pages,
  input  logic [ara_pkg::ATTR_W-1:0] rgt_attr,
  input  ara_pkg::flags_t           rgt_flags,
  output logic [W-1:0]              start,
  output logic [W-1:0]              pages,
  output logic [ara_pkg::ATTR_W-1:0] attr,
  output ara_pkg::flags_t           flags
);

  logic         cov;
  logic         spl;
  logic [W-1:0] end_pg;
  logic [W-1:0] lft_end;
  logic [W-1:0] key;
  logic         keep;
  logic         cut_lo;
  logic         cut_hi;

  assign end_pg  = start + pages;
  assign lft_end = lft_start + lft_pages;
  assign key     = (cmd == ara_pkg::CMD_SPLIT) ? h1 : new_start;
  assign keep    = (end_pg <= h0) || (start >= h1);
  assign cut_lo  = start < h0;
  assign cut_hi  = end_pg > h1;

  assign flags.ge  = !valid || (start >= key);
  assign flags.cov = cov & valid;
  assign flags.spl = spl & valid;

  always_ff @(posedge clk) begin
    unique case (cmd)
      ara_pkg::CMD_ROTATE: begin
        start <= rgt_start;
        pages <= rgt_pages;
        attr  <= rgt_attr;
        cov   <= rgt_flags.cov;
        spl   <= rgt_flags.spl;
      end
      ara_pkg::CMD_FLAGS: begin
        cov <= valid && !keep && !cut_lo && !cut_hi;
        spl <= valid && !keep && cut_lo && cut_hi;
      end
      ara_pkg::CMD_TRIM: begin
        if (valid && !keep) begin
          if (cut_lo && !cut_hi) begin
            pages <= h0 - start;
          end else if (cut_hi && !cut_lo) begin
            start <= h1;
            pages <= end_pg - h1;
          end
        end
      end
      ara_pkg::CMD_REMOVE: begin
        // close up the first covered slot
        if (valid && start >= h0) begin
          start <= rgt_start;
          pages <= rgt_pages;
          attr  <= rgt_attr;
          cov   <= rgt_flags.cov;
          spl   <= rgt_flags.spl;
        end
      end
      ara_pkg::CMD_SPLIT, ara_pkg::CMD_INSERT: begin
        if (flags.ge) begin
          if (lft_flags.ge) begin
            start <= lft_start;
            pages <= lft_pages;
            attr  <= lft_attr;
            cov   <= lft_flags.cov;
            spl   <= lft_flags.spl;
          end else if (cmd == ara_pkg::CMD_SPLIT) begin
            // upper piece of the straddling neighbor
            start <= h1;
            pages <= lft_end - h1;
            attr  <= lft_attr;
            cov   <= 1'b0;
            spl   <= 1'b0;
          end else begin
            start <= new_start;
            pages <= new_pages;
            attr  <= new_attr;
            cov   <= 1'b0;
            spl   <= 1'b0;
          end
        end else if (cmd == ara_pkg::CMD_SPLIT && spl) begin
          pages <= h0 - start;
          spl   <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/ara_gap_scan.sv =====
module ara_gap_scan #(
  parameter int W = 37
) (
  input  logic         clk,
  input  logic         load,
  input  logic [W-1:0] from,
  input  logic         step,
  input  logic [W-1:0] start,
  input  logic [W-1:0] pages,
  input  logic [W-1:0] n,
  output logic [W-1:0] cand
);

  logic         done;
  logic [W-1:0] reach;
  logic [W-1:0] end_pg;

  assign reach  = cand + n;
  assign end_pg = start + pages;

  always_ff @(posedge clk) begin
    if (load) begin
      cand <= from;
      done <= 1'b0;
    end else if (step && !done) begin
      if (start >= reach) begin
        done <= 1'b1;
      end else if (end_pg > cand) begin
        cand <= end_pg;
      end
    end
  end

endmodule

// ===== src/address_range_allocator_top.sv =====
// Page-range allocator. Requests arrive as stream beats (opcode in tuser) and
// each gives exactly one result beat. The range table lives in a chain of
// MAX_RANGES cells kept in start order. Reserve runs a next-fit gap search by
// rotating the whole chain past a scan unit, one full rotation per pass, one
// pass or two when the search wraps to the base page; fixed map and unmap skip
// the search. Every table update then runs flag, check and trim steps, one
// remove step per range that the new hole covers entirely, a split step when
// a range is split and an insert step for map and reserve, then the result
// step; a rejected or untracked request goes straight to the result step.
// Requests are handled one at a time, and the next one is taken while the
// previous result still waits on the output.
// After reset the table is empty; no clearing pass is needed.
module address_range_allocator_top #(
  parameter int MAX_RANGES = 64,
  parameter int PAGE_SHIFT = 12,
  parameter int ADDR_BITS  = 47
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // address [46:0], length_bytes [93:47], protection [96:94], zero fill
  input  logic [103:0] s_axis_tdata,
  // opcode [1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_address [46:0], status [48:47], zero fill
  output logic [55:0]  m_axis_tdata,
  input  logic         cfg_we,
  input  logic [34:0]  cfg_data
);

  localparam int PW  = ADDR_BITS - PAGE_SHIFT;
  localparam int W   = ((PW > ara_pkg::BASE_W) ? PW : ara_pkg::BASE_W) + 2;
  localparam int CW  = $clog2(MAX_RANGES + 1);
  localparam int KW  = $clog2(MAX_RANGES);
  localparam int PGW = ara_pkg::LEN_W - PAGE_SHIFT + 1;
  localparam logic [35:0] BASE_RST = ara_pkg::REGION_BASE_ADDR >> PAGE_SHIFT;
  localparam logic [W-1:0] SPACE_PAGES = W'(1) << PW;

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_DECODE     = 4'd1;
  localparam logic [3:0] S_SEARCH     = 4'd2;
  localparam logic [3:0] S_SEARCH_END = 4'd3;
  localparam logic [3:0] S_FLAGS      = 4'd4;
  localparam logic [3:0] S_CHECK      = 4'd5;
  localparam logic [3:0] S_TRIM       = 4'd6;
  localparam logic [3:0] S_REMOVE     = 4'd7;
  localparam logic [3:0] S_SPLIT      = 4'd8;
  localparam logic [3:0] S_INSERT     = 4'd9;
  localparam logic [3:0] S_DONE       = 4'd10;

  logic [3:0]                  state;
  logic [ara_pkg::OPC_W-1:0]   op_r;
  logic [ara_pkg::ADDR_W-1:0]  addr_r;
  logic [ara_pkg::LEN_W-1:0]   len_r;
  logic [ara_pkg::PROT_W-1:0]  prot_r;
  logic [W-1:0]                n_r;
  logic [W-1:0]                h0;
  logic [W-1:0]                h1;
  logic                        ins_r;
  logic [ara_pkg::ADDR_W-1:0]  res_r;
  logic [ara_pkg::STAT_W-1:0]  status_r;
  logic [W-1:0]                from_r;
  logic                        pass_r;
  logic [KW-1:0]               k;
  logic [CW-1:0]               count;
  logic [W-1:0]                cursor;
  logic [ara_pkg::BASE_W-1:0]  base;

  ara_pkg::cmd_t               cmd;
  logic [ara_pkg::ATTR_W-1:0]  attr_new;
  logic [PGW-1:0]              pg;
  logic [W-1:0]                s_pg;
  logic [W-1:0]                pg_w;
  logic [W-1:0]                n_res;
  logic [W-1:0]                base_w;
  logic [W-1:0]                cur;
  logic                        misaligned;
  logic [W-1:0]                cand;
  logic [W-1:0]                cand_end;
  logic                        scan_load;
  logic [W-1:0]                scan_from;
  logic                        head_valid;
  logic                        any_cov;
  logic                        any_spl;
  logic                        full;
  logic [W+PAGE_SHIFT-1:0]     cand_byte;

  logic [W-1:0]                c_start [MAX_RANGES];
  logic [W-1:0]                c_pages [MAX_RANGES];
  logic [ara_pkg::ATTR_W-1:0]  c_attr  [MAX_RANGES];
  ara_pkg::flags_t             c_flags [MAX_RANGES];
  logic [MAX_RANGES-1:0]       cov_vec;
  logic [MAX_RANGES-1:0]       spl_vec;

  assign s_axis_tready = (state == S_IDLE);

  // Decode helpers on the held request.
  assign attr_new   = {|prot_r, prot_r};
  assign pg         = PGW'(len_r >> PAGE_SHIFT) + PGW'(|len_r[PAGE_SHIFT-1:0]);
  assign pg_w       = W'(pg);
  assign s_pg       = W'(addr_r >> PAGE_SHIFT);
  assign n_res      = (pg == '0) ? W'(1) : pg_w;
  assign base_w     = W'(base);
  assign cur        = (cursor == '0 || cursor < base_w) ? base_w : cursor;
  assign misaligned = |addr_r[PAGE_SHIFT-1:0];
  assign cand_end   = cand + n_r;
  assign cand_byte  = {cand, {PAGE_SHIFT{1'b0}}};
  assign head_valid = CW'(k) < count;
  assign any_cov    = |cov_vec;
  assign any_spl    = |spl_vec;

  // A split adds one entry, an insert one more; covered entries free slots.
  always_comb begin
    if (any_spl) begin
      full = ({1'b0, count} + (CW+1)'(1) + (CW+1)'(ins_r)) > (CW+1)'(MAX_RANGES);
    end else begin
      full = ins_r && !any_cov && (count == CW'(MAX_RANGES));
    end
  end

  always_comb begin
    unique case (state)
      S_SEARCH: cmd = ara_pkg::CMD_ROTATE;
      S_FLAGS:  cmd = ara_pkg::CMD_FLAGS;
      S_TRIM:   cmd = ara_pkg::CMD_TRIM;
      S_REMOVE: cmd = any_cov ? ara_pkg::CMD_REMOVE : ara_pkg::CMD_HOLD;
      S_SPLIT:  cmd = ara_pkg::CMD_SPLIT;
      S_INSERT: cmd = ara_pkg::CMD_INSERT;
      default:  cmd = ara_pkg::CMD_HOLD;
    endcase
  end

  // Load the scan unit for the first pass at decode, the wrap pass afterwards.
  always_comb begin
    scan_load = 1'b0;
    scan_from = cur;
    if (state == S_DECODE && op_r == ara_pkg::OP_RESERVE) begin
      scan_load = 1'b1;
    end else if (state == S_SEARCH_END) begin
      scan_load = 1'b1;
      scan_from = base_w;
    end
  end

  ara_gap_scan #(
    .W(W)
  ) u_scan (
    .clk  (clk),
    .load (scan_load),
    .from (scan_from),
    .step ((state == S_SEARCH) && head_valid),
    .start(c_start[0]),
    .pages(c_pages[0]),
    .n    (n_r),
    .cand (cand)
  );

  // Range chain: each cell trades entries with its neighbors; the last cell
  // takes from cell zero so a full rotation restores the order.
  for (genvar j = 0; j < MAX_RANGES; j++) begin : g_cell
    logic [W-1:0]               l_start;
    logic [W-1:0]               l_pages;
    logic [ara_pkg::ATTR_W-1:0] l_attr;
    ara_pkg::flags_t            l_flags;
    logic [W-1:0]               r_start;
    logic [W-1:0]               r_pages;
    logic [ara_pkg::ATTR_W-1:0] r_attr;
    ara_pkg::flags_t            r_flags;

    if (j == 0) begin : g_first
      assign l_start = '0;
      assign l_pages = '0;
      assign l_attr  = '0;
      assign l_flags = '0;
    end else begin : g_mid
      assign l_start = c_start[j-1];
      assign l_pages = c_pages[j-1];
      assign l_attr  = c_attr[j-1];
      assign l_flags = c_flags[j-1];
    end

    if (j == MAX_RANGES - 1) begin : g_last
      assign r_start = c_start[0];
      assign r_pages = c_pages[0];
      assign r_attr  = c_attr[0];
      assign r_flags = c_flags[0];
    end else begin : g_next
      assign r_start = c_start[j+1];
      assign r_pages = c_pages[j+1];
      assign r_attr  = c_attr[j+1];
      assign r_flags = c_flags[j+1];
    end

    ara_cell #(
      .W(W)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .valid    (CW'(j) < count),
      .h0       (h0),
      .h1       (h1),
      .new_start(h0),
      .new_pages(n_r),
      .new_attr (attr_new),
      .lft_start(l_start),
      .lft_pages(l_pages),
      .lft_attr (l_attr),
      .lft_flags(l_flags),
      .rgt_start(r_start),
      .rgt_pages(r_pages),
      .rgt_attr (r_attr),
      .rgt_flags(r_flags),
      .start    (c_start[j]),
      .pages    (c_pages[j]),
      .attr     (c_attr[j]),
      .flags    (c_flags[j])
    );

    assign cov_vec[j] = c_flags[j].cov;
    assign spl_vec[j] = c_flags[j].spl;
  end

  // Hold the request beat.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_axis_tvalid) begin
      op_r   <= s_axis_tuser;
      addr_r <= s_axis_tdata[46:0];
      len_r  <= s_axis_tdata[93:47];
      prot_r <= s_axis_tdata[96:94];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      cursor        <= '0;
      base          <= BASE_RST[ara_pkg::BASE_W-1:0];
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        base <= cfg_data;
      end
      // the done state reloads the output register itself
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            state <= S_DECODE;
          end
        end

        S_DECODE: begin
          res_r    <= '0;
          status_r <= ara_pkg::ST_OK;
          ins_r    <= 1'b0;
          unique case (op_r)
            ara_pkg::OP_RESERVE: begin
              n_r    <= n_res;
              from_r <= cur;
              pass_r <= 1'b0;
              k      <= '0;
              state  <= S_SEARCH;
            end
            ara_pkg::OP_MAP: begin
              if (len_r == '0 || misaligned) begin
                status_r <= ara_pkg::ST_INVAL;
                state    <= S_DONE;
              end else if (s_pg + pg_w > SPACE_PAGES) begin
                status_r <= ara_pkg::ST_NOSPACE;
                state    <= S_DONE;
              end else if (s_pg < base_w) begin
                // below the tracked region: echo and leave the table alone
                res_r <= addr_r;
                state <= S_DONE;
              end else begin
                res_r <= addr_r;
                h0    <= s_pg;
                h1    <= s_pg + pg_w;
                n_r   <= pg_w;
                ins_r <= 1'b1;
                state <= S_FLAGS;
              end
            end
            ara_pkg::OP_UNMAP: begin
              if (misaligned) begin
                status_r <= ara_pkg::ST_INVAL;
                state    <= S_DONE;
              end else if (len_r == '0) begin
                state <= S_DONE;
              end else begin
                h0    <= s_pg;
                h1    <= s_pg + pg_w;
                n_r   <= pg_w;
                state <= S_FLAGS;
              end
            end
            default: begin
              status_r <= ara_pkg::ST_INVAL;
              state    <= S_DONE;
            end
          endcase
        end

        S_SEARCH: begin
          k <= k + KW'(1);
          if (k == KW'(MAX_RANGES - 1)) begin
            state <= S_SEARCH_END;
          end
        end

        S_SEARCH_END: begin
          k <= '0;
          if (cand_end <= SPACE_PAGES) begin
            h0    <= cand;
            h1    <= cand_end;
            ins_r <= 1'b1;
            res_r <= cand_byte[ara_pkg::ADDR_W-1:0];
            state <= S_FLAGS;
          end else if (!pass_r && from_r != base_w) begin
            // wrap the search to the base page
            pass_r <= 1'b1;
            state  <= S_SEARCH;
          end else begin
            status_r <= ara_pkg::ST_NOSPACE;
            state    <= S_DONE;
          end
        end

        S_FLAGS: begin
          state <= S_CHECK;
        end

        S_CHECK: begin
          if (full) begin
            status_r <= ara_pkg::ST_FULL;
            state    <= S_DONE;
          end else begin
            state <= S_TRIM;
          end
        end

        S_TRIM: begin
          state <= S_REMOVE;
        end

        S_REMOVE: begin
          if (any_cov) begin
            count <= count - CW'(1);
          end else if (any_spl) begin
            state <= S_SPLIT;
          end else if (ins_r) begin
            state <= S_INSERT;
          end else begin
            state <= S_DONE;
          end
        end

        S_SPLIT: begin
          count <= count + CW'(1);
          state <= ins_r ? S_INSERT : S_DONE;
        end

        S_INSERT: begin
          count <= count + CW'(1);
          state <= S_DONE;
        end

        S_DONE: begin
          // drop the result into the output register once it is free
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {7'd0, status_r,
                              (status_r == ara_pkg::ST_OK) ? res_r : '0};
            if (op_r == ara_pkg::OP_RESERVE && status_r == ara_pkg::ST_OK) begin
              cursor <= W'(h1[PW-1:0]);
            end
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
